// ===== rtl/pslx_pkg.sv =====
package pslx_pkg;

    localparam int MAX_LEXEME_DEF    = 32;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int NUM_KEYWORDS      = 13;
    localparam int LEN_W             = 7;

    localparam logic [4:0] K_KEYWORD = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_NUMBER  = 5'd2;
    localparam logic [4:0] K_PLUS    = 5'd3;
    localparam logic [4:0] K_MINUS   = 5'd4;
    localparam logic [4:0] K_STAR    = 5'd5;
    localparam logic [4:0] K_SLASH   = 5'd6;
    localparam logic [4:0] K_EQ      = 5'd7;
    localparam logic [4:0] K_GT      = 5'd8;
    localparam logic [4:0] K_GE      = 5'd9;
    localparam logic [4:0] K_LT      = 5'd10;
    localparam logic [4:0] K_LE      = 5'd11;
    localparam logic [4:0] K_NE      = 5'd12;
    localparam logic [4:0] K_SEMI    = 5'd13;
    localparam logic [4:0] K_COMMA   = 5'd14;
    localparam logic [4:0] K_LPAREN  = 5'd15;
    localparam logic [4:0] K_RPAREN  = 5'd16;
    localparam logic [4:0] K_LBRACE  = 5'd17;
    localparam logic [4:0] K_RBRACE  = 5'd18;
    localparam logic [4:0] K_ERROR   = 5'd19;
    localparam logic [4:0] K_EOF     = 5'd20;

    localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
        64'("program"), 64'("var"), 64'("integer"), 64'("real"), 64'("begin"),
        64'("end"), 64'("if"), 64'("then"), 64'("else"), 64'("while"),
        64'("do"), 64'("write"), 64'("read")
    };
    localparam int KW_LEN [NUM_KEYWORDS] = '{7, 3, 7, 4, 5, 3, 2, 4, 4, 5, 2, 5, 4};

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_GT,
        M_LT
    } scan_mode_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CLASS,
        B_LEN,
        B_LCHK,
        B_CRD,
        B_CCHK,
        B_NEW,
        B_WR,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        logic [4:0]       kind;
        logic [LEN_W-1:0] len;
        logic             trunc;
        logic [31:0]      value;
        logic [15:0]      line;
        logic [15:0]      col;
        logic             last;
    } req_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [3:0]  kw;
        logic [5:0]  slot;
        logic        full;
        logic [31:0] value;
        logic [5:0]  len;
        logic        trunc;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } tok_t;

    // bit 4 is the hit flag, low bits the keyword index
    function automatic logic [4:0] kw_find(input logic [63:0] lex8, input logic [LEN_W-1:0] n);
        logic [4:0] res;
        logic       eq;
        res = 5'd0;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            eq = (n == LEN_W'(KW_LEN[k]));
            for (int j = 0; j < 8; j++) begin
                if (j < KW_LEN[k]) begin
                    if (lex8[j*8 +: 8] != KW_TEXT[k][(KW_LEN[k]-1-j)*8 +: 8]) begin
                        eq = 1'b0;
                    end
                end
            end
            if (eq) begin
                res = {1'b1, 4'(k)};
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/pslx_fifo.sv =====
module pslx_fifo
    import pslx_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rdata   = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/pslx_front.sv =====
module pslx_front
    import pslx_pkg::*;
#(
    parameter int MAX_LEXEME = MAX_LEXEME_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              in_byte,
    input  logic                    end_of_input,
    output logic                    q_push,
    output req_t                    q_req,
    output logic [MAX_LEXEME*8-1:0] q_lex,
    input  logic                    q_full
);

    localparam int IW = $clog2(MAX_LEXEME);
    localparam int CW = $clog2(MAX_LEXEME + 1);

    scan_mode_t              mode_reg, mode_next;
    logic [MAX_LEXEME*8-1:0] lex_reg, lex_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    over_reg, over_next;
    logic [31:0]             acc_reg, acc_next;
    logic [15:0]             line_reg, line_next, col_reg, col_next, col_inc;
    req_t                    pend_reg, pend_next;
    logic                    pend_v_reg, pend_v_next;

    logic        accept, is_alpha, is_digit, is_space;
    logic [3:0]  dig;
    logic [35:0] mac;
    req_t        ft, t0, t1, first, second;
    logic        ft_v, v0, v1;

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        case (c)
            8'h2B:   return K_PLUS;
            8'h2D:   return K_MINUS;
            8'h2A:   return K_STAR;
            8'h2F:   return K_SLASH;
            8'h3D:   return K_EQ;
            8'h3B:   return K_SEMI;
            8'h2C:   return K_COMMA;
            8'h28:   return K_LPAREN;
            8'h29:   return K_RPAREN;
            8'h7B:   return K_LBRACE;
            8'h7D:   return K_RBRACE;
            default: return K_ERROR;
        endcase
    endfunction

    assign full     = pend_v_reg || q_full;
    assign accept   = push && !full;
    assign is_alpha = (in_byte >= 8'h61 && in_byte <= 8'h7A) ||
                      (in_byte >= 8'h41 && in_byte <= 8'h5A);
    assign is_digit = (in_byte >= 8'h30 && in_byte <= 8'h39);
    assign is_space = (in_byte == 8'h20) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
    assign dig      = 4'(in_byte - 8'h30);
    assign mac      = {4'b0, acc_reg} * 36'd10 + {32'b0, dig};
    assign col_inc  = (col_reg != 16'hFFFF) ? col_reg + 16'd1 : col_reg;
    assign q_lex    = lex_reg;

    always_comb
    begin
        ft       = '0;
        ft.line  = line_reg;
        ft.col   = col_reg;
        ft_v     = 1'b1;
        case (mode_reg)
            M_IDENT:
            begin
                ft.kind  = K_IDENT;
                ft.len   = LEN_W'(cnt_reg);
                ft.trunc = over_reg;
            end
            M_NUMBER:
            begin
                ft.kind  = K_NUMBER;
                ft.len   = LEN_W'(cnt_reg);
                ft.trunc = over_reg;
                ft.value = acc_reg;
            end
            M_GT:
            begin
                ft.kind = K_GT;
                ft.len  = LEN_W'(1);
            end
            M_LT:
            begin
                ft.kind = K_LT;
                ft.len  = LEN_W'(1);
            end
            default:
            begin
                ft_v = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        lex_next    = lex_reg;
        cnt_next    = cnt_reg;
        over_next   = over_reg;
        acc_next    = acc_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        t0          = ft;
        t1          = '0;
        t1.line     = line_reg;
        t1.col      = col_inc;
        v0          = 1'b0;
        v1          = 1'b0;

        if (end_of_input)
        begin
            v0        = ft_v;
            t1.kind   = K_EOF;
            t1.col    = col_reg;
            v1        = 1'b1;
            mode_next = M_IDLE;
        end
        else if ((mode_reg == M_IDENT && (is_alpha || is_digit)) ||
                 (mode_reg == M_NUMBER && is_digit))
        begin
            col_next = col_inc;
            if (cnt_reg < CW'(MAX_LEXEME))
            begin
                lex_next[cnt_reg[IW-1:0]*8 +: 8] = in_byte;
                cnt_next = cnt_reg + CW'(1);
            end
            else
            begin
                over_next = 1'b1;
            end
            if (mode_reg == M_NUMBER)
            begin
                acc_next = (mac[35:32] != 4'd0) ? 32'hFFFF_FFFF : mac[31:0];
            end
        end
        else if ((mode_reg == M_GT && in_byte == 8'h3D) ||
                 (mode_reg == M_LT && (in_byte == 8'h3D || in_byte == 8'h3E)))
        begin
            col_next  = col_inc;
            t1.kind   = (mode_reg == M_GT) ? K_GE : ((in_byte == 8'h3D) ? K_LE : K_NE);
            t1.len    = LEN_W'(2);
            v1        = 1'b1;
            mode_next = M_IDLE;
        end
        else
        begin
            v0        = ft_v;
            mode_next = M_IDLE;
            col_next  = col_inc;
            if (is_space)
            begin
                if (in_byte == 8'h0A)
                begin
                    if (line_reg != 16'hFFFF)
                    begin
                        line_next = line_reg + 16'd1;
                    end
                    col_next = 16'd0;
                end
            end
            else if (is_alpha || is_digit)
            begin
                mode_next     = is_alpha ? M_IDENT : M_NUMBER;
                lex_next[7:0] = in_byte;
                cnt_next      = CW'(1);
                over_next     = 1'b0;
                acc_next      = is_alpha ? 32'd0 : {28'd0, dig};
            end
            else if (in_byte == 8'h3E)
            begin
                mode_next = M_GT;
            end
            else if (in_byte == 8'h3C)
            begin
                mode_next = M_LT;
            end
            else
            begin
                t1.kind = single_kind(in_byte);
                t1.len  = LEN_W'(1);
                v1      = 1'b1;
            end
        end

        first       = v0 ? t0 : t1;
        second      = t1;
        first.last  = !(v0 && v1);
        second.last = 1'b1;

        q_push = 1'b0;
        q_req  = pend_reg;
        if (pend_v_reg)
        begin
            q_push = !q_full;
            if (!q_full)
            begin
                pend_v_next = 1'b0;
            end
        end
        else if (accept)
        begin
            q_push = v0 || v1;
            q_req  = first;
            if (v0 && v1)
            begin
                pend_next   = second;
                pend_v_next = 1'b1;
            end
        end

        if (!accept)
        begin
            mode_next = mode_reg;
            lex_next  = lex_reg;
            cnt_next  = cnt_reg;
            over_next = over_reg;
            acc_next  = acc_reg;
            line_next = line_reg;
            col_next  = col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            cnt_reg    <= '0;
            over_reg   <= 1'b0;
            acc_reg    <= '0;
            line_reg   <= 16'd1;
            col_reg    <= 16'd0;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            cnt_reg    <= cnt_next;
            over_reg   <= over_next;
            acc_reg    <= acc_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            pend_v_reg <= pend_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lex_reg  <= lex_next;
        pend_reg <= pend_next;
    end

endmodule

// ===== rtl/pslx_back.sv =====
module pslx_back
    import pslx_pkg::*;
#(
    parameter int MAX_LEXEME    = MAX_LEXEME_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  req_t                    q_req,
    input  logic [MAX_LEXEME*8-1:0] q_lex,
    output logic                    q_pop,
    output logic                    o_push,
    output tok_t                    o_tok,
    input  logic                    o_full
);

    localparam int IW  = $clog2(MAX_LEXEME);
    localparam int TIW = $clog2(TABLE_ENTRIES);
    localparam int TCW = $clog2(TABLE_ENTRIES + 1);
    localparam int AW  = $clog2(TABLE_ENTRIES * MAX_LEXEME);

    logic [7:0]       chars_mem [TABLE_ENTRIES*MAX_LEXEME];
    logic [LEN_W-1:0] lens_mem  [TABLE_ENTRIES];

    back_state_t             st_reg, st_next;
    req_t                    wk_reg;
    logic [MAX_LEXEME*8-1:0] lex_reg;
    logic [4:0]              kind_reg, kind_next;
    logic [3:0]              kw_reg, kw_next;
    logic [TIW-1:0]          slot_reg, slot_next, i_reg, i_next;
    logic                    full_reg, full_next;
    logic [IW-1:0]           j_reg, j_next;
    logic [TCW-1:0]          cnt_reg, cnt_next;
    logic [LEN_W-1:0]        len_rd;
    logic [7:0]              ch_rd;

    logic [4:0]    kw_hit;
    logic [7:0]    lex_byte;
    logic          j_last, i_last;
    logic [AW-1:0] raddr, waddr;
    logic          ch_we, len_we;

    assign kw_hit   = kw_find(lex_reg[63:0], wk_reg.len);
    assign lex_byte = lex_reg[j_reg*8 +: 8];
    assign j_last   = (LEN_W'(j_reg) + LEN_W'(1) == wk_reg.len);
    assign i_last   = (TCW'(i_reg) + TCW'(1) == cnt_reg);
    assign raddr    = AW'(i_reg) * AW'(MAX_LEXEME) + AW'(j_reg);
    assign waddr    = AW'(cnt_reg[TIW-1:0]) * AW'(MAX_LEXEME) + AW'(j_reg);
    assign q_pop    = (st_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        o_tok       = '0;
        o_tok.kind  = kind_reg;
        o_tok.kw    = kw_reg;
        o_tok.slot  = 6'(slot_reg);
        o_tok.full  = full_reg;
        o_tok.value = wk_reg.value;
        o_tok.len   = 6'(wk_reg.len);
        o_tok.trunc = wk_reg.trunc;
        o_tok.line  = wk_reg.line;
        o_tok.col   = wk_reg.col;
        o_tok.last  = wk_reg.last;
    end

    always_comb
    begin
        st_next   = st_reg;
        kind_next = kind_reg;
        kw_next   = kw_reg;
        slot_next = slot_reg;
        full_next = full_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        cnt_next  = cnt_reg;
        ch_we     = 1'b0;
        len_we    = 1'b0;
        o_push    = 1'b0;
        case (st_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    st_next = B_CLASS;
                end
            end
            B_CLASS:
            begin
                kind_next = wk_reg.kind;
                kw_next   = 4'd0;
                slot_next = '0;
                full_next = 1'b0;
                i_next    = '0;
                j_next    = '0;
                if (wk_reg.kind != K_IDENT)
                begin
                    st_next = B_EMIT;
                end
                else if (!wk_reg.trunc && kw_hit[4])
                begin
                    kind_next = K_KEYWORD;
                    kw_next   = kw_hit[3:0];
                    st_next   = B_EMIT;
                end
                else if (cnt_reg == '0)
                begin
                    st_next = B_NEW;
                end
                else
                begin
                    st_next = B_LEN;
                end
            end
            B_LEN:
            begin
                st_next = B_LCHK;
            end
            B_LCHK:
            begin
                j_next = '0;
                if (len_rd == wk_reg.len)
                begin
                    st_next = B_CRD;
                end
                else if (i_last)
                begin
                    st_next = B_NEW;
                end
                else
                begin
                    i_next  = i_reg + TIW'(1);
                    st_next = B_LEN;
                end
            end
            B_CRD:
            begin
                st_next = B_CCHK;
            end
            B_CCHK:
            begin
                if (ch_rd != lex_byte)
                begin
                    if (i_last)
                    begin
                        st_next = B_NEW;
                    end
                    else
                    begin
                        i_next  = i_reg + TIW'(1);
                        st_next = B_LEN;
                    end
                end
                else if (j_last)
                begin
                    slot_next = i_reg;
                    st_next   = B_EMIT;
                end
                else
                begin
                    j_next  = j_reg + IW'(1);
                    st_next = B_CRD;
                end
            end
            B_NEW:
            begin
                j_next = '0;
                if (cnt_reg >= TCW'(TABLE_ENTRIES))
                begin
                    full_next = 1'b1;
                    st_next   = B_EMIT;
                end
                else
                begin
                    st_next = B_WR;
                end
            end
            B_WR:
            begin
                ch_we = 1'b1;
                if (j_last)
                begin
                    len_we    = 1'b1;
                    slot_next = cnt_reg[TIW-1:0];
                    cnt_next  = cnt_reg + TCW'(1);
                    st_next   = B_EMIT;
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end
            B_EMIT:
            begin
                o_push = 1'b1;
                if (!o_full)
                begin
                    st_next = B_IDLE;
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= B_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            wk_reg  <= q_req;
            lex_reg <= q_lex;
        end
        kind_reg <= kind_next;
        kw_reg   <= kw_next;
        slot_reg <= slot_next;
        full_reg <= full_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
    end

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            chars_mem[waddr] <= lex_byte;
        end
        if (len_we)
        begin
            lens_mem[cnt_reg[TIW-1:0]] <= wk_reg.len;
        end
        ch_rd  <= chars_mem[raddr];
        len_rd <= lens_mem[i_reg];
    end

endmodule

// ===== rtl/pascal_subset_lexer.sv =====
// pascal subset lexer
// input queue: drive in_byte / end_of_input with push; a byte is taken on a
// clock edge where push is high and full is low
// result queue: while empty is low the oldest token sits on the token ports;
// raise pop to take it
// the scanner takes one byte per cycle while full is low; a byte that yields two
// tokens holds full high while the second one is queued
// operators, numbers and eof pass from the scanner through the token queue,
// the sequencer (B_IDLE, B_CLASS, B_EMIT) and the result queue; an identifier
// that is no keyword also walks the stored entries (B_LEN, B_LCHK, then B_CRD
// and B_CCHK per character compared) and, when it is entered, B_NEW and B_WR
// per character; the sequencer takes a new request only once it has emitted the last one
// a stalled result queue backs up into the token queue and then raises full;
// nothing is dropped
// reset empties both queues, returns to line 1 column 0 and empties the
// symbol table at once, with no clearing pass
module pascal_subset_lexer
    import pslx_pkg::*;
#(
    parameter int MAX_LEXEME    = MAX_LEXEME_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  token_kind,
    output logic [3:0]  keyword_index,
    output logic [5:0]  symbol_slot,
    output logic        table_full,
    output logic [31:0] number_value,
    output logic [5:0]  lexeme_length,
    output logic        truncated,
    output logic [15:0] line_number,
    output logic [15:0] column_number,
    output logic        last
);

    localparam int QW = $bits(req_t) + MAX_LEXEME * 8;

    logic                    q_push, q_full, q_pop, q_empty;
    req_t                    q_req_w, q_req_r;
    logic [MAX_LEXEME*8-1:0] q_lex_w, q_lex_r;
    logic                    o_push, o_full;
    tok_t                    o_tok_w, o_tok_r;

    pslx_front #(.MAX_LEXEME(MAX_LEXEME)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .q_push       (q_push),
        .q_req        (q_req_w),
        .q_lex        (q_lex_w),
        .q_full       (q_full)
    );

    pslx_fifo #(.WIDTH(QW), .DEPTH(2)) u_req_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({q_req_w, q_lex_w}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata ({q_req_r, q_lex_r}),
        .empty (q_empty)
    );

    pslx_back #(.MAX_LEXEME(MAX_LEXEME), .TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_req   (q_req_r),
        .q_lex   (q_lex_r),
        .q_pop   (q_pop),
        .o_push  (o_push),
        .o_tok   (o_tok_w),
        .o_full  (o_full)
    );

    pslx_fifo #(.WIDTH($bits(tok_t)), .DEPTH(2)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .wdata (o_tok_w),
        .full  (o_full),
        .pop   (pop),
        .rdata (o_tok_r),
        .empty (empty)
    );

    assign token_kind    = o_tok_r.kind;
    assign keyword_index = o_tok_r.kw;
    assign symbol_slot   = o_tok_r.slot;
    assign table_full    = o_tok_r.full;
    assign number_value  = o_tok_r.value;
    assign lexeme_length = o_tok_r.len;
    assign truncated     = o_tok_r.trunc;
    assign line_number   = o_tok_r.line;
    assign column_number = o_tok_r.col;
    assign last          = o_tok_r.last;

endmodule

// ===== rtl/pslx_checker.sv =====
module pslx_checker
    import pslx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [4:0]  token_kind,
    input logic [3:0]  keyword_index,
    input logic [5:0]  symbol_slot,
    input logic        table_full,
    input logic        last
);

    // a waiting token holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(token_kind)))
        else $error("waiting token changed");

    // end of file always closes the results of its byte
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && token_kind == K_EOF) |-> last)
        else $error("eof without last");

    a_kw_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && token_kind != K_KEYWORD) |-> (keyword_index == 4'd0))
        else $error("keyword index on non-keyword");

    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && table_full) |-> (symbol_slot == 6'd0 && token_kind == K_IDENT))
        else $error("table full flag inconsistent");

endmodule

bind pascal_subset_lexer pslx_checker u_pslx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .token_kind    (token_kind),
    .keyword_index (keyword_index),
    .symbol_slot   (symbol_slot),
    .table_full    (table_full),
    .last          (last)
);
